// ----- src/sbph_pkg.sv -----
package sbph_pkg;

  // Field widths
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned HEIGHT_W = 7;
  localparam int unsigned HOLD_W   = 8;

  // Bar scale and reset hold length
  localparam int unsigned             BAR_MAX_I  = 90;
  localparam logic [HEIGHT_W-1:0]     BAR_MAX    = HEIGHT_W'(BAR_MAX_I);
  localparam logic [HOLD_W-1:0]       HOLD_RESET = HOLD_W'(20);

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register map
  localparam logic [1:0] ADDR_HOLD_FRAMES = 2'd0;

  // One result item
  typedef struct packed {
    logic [HEIGHT_W-1:0] bar_height;
    logic [HEIGHT_W-1:0] peak_height;
    logic                peak_shown;
  } res_t;

endpackage

// ----- src/sbph_front.sv -----
module sbph_front import sbph_pkg::*; #(
  parameter int BINS       = 128,
  parameter int CHANNELS   = 2,
  parameter int FULL_SCALE = 65535,
  parameter int IDX_W      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear_busy,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                channel,
  input  logic [6:0]          bin,
  input  logic [MAG_W-1:0]    magnitude,
  output logic                push,
  output logic [IDX_W-1:0]    push_idx,
  output logic                push_inr,
  output logic [HEIGHT_W-1:0] push_height,
  input  logic                q_full
);

  // Reciprocal of the full scale, times 90 * 2^16, rounded down
  localparam int RECIP_W = 23;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int QE_W    = PROD_W - 16;
  localparam int X_W     = MAG_W + HEIGHT_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((BAR_MAX_I * 65536) / FULL_SCALE);

  logic                v1;
  logic [QE_W-1:0]     qe1;
  logic [MAG_W-1:0]    mag1;
  logic [IDX_W-1:0]    idx1;
  logic                inr1;

  logic                v2;
  logic                qbig2;
  logic [HEIGHT_W-1:0] qe2;
  logic [X_W-1:0]      qfs2;
  logic [X_W-1:0]      x2;
  logic [IDX_W-1:0]    idx2;
  logic                inr2;

  logic                en1;
  logic                en2;
  logic                accept;
  logic [PROD_W-1:0]   prod;
  logic [X_W-1:0]      rem;
  logic                in_range;
  logic [IDX_W-1:0]    idx_in;

  // Stage advance control
  assign en2      = !v2 || !q_full;
  assign en1      = !v1 || en2;
  assign in_stall = clear_busy || (v1 && !en2);
  assign accept   = in_valid && !in_stall;

  // Classify the item and form its store index
  assign in_range = (32'(channel) < CHANNELS) && (32'(bin) < BINS);
  assign idx_in   = IDX_W'(32'(channel) * BINS + 32'(bin));

  // Estimate the quotient by reciprocal multiply
  assign prod = PROD_W'(magnitude) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
    if (en1 && accept) begin
      qe1  <= prod[PROD_W-1:16];
      mag1 <= magnitude;
      idx1 <= idx_in;
      inr1 <= in_range;
    end
  end

  // Form the exact product and the estimate times the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      qbig2 <= qe1 >= QE_W'(BAR_MAX_I);
      qe2   <= qe1[HEIGHT_W-1:0];
      qfs2  <= X_W'(qe1[HEIGHT_W-1:0]) * X_W'(FULL_SCALE);
      x2    <= X_W'(mag1) * X_W'(BAR_MAX_I);
      idx2  <= idx1;
      inr2  <= inr1;
    end
  end

  // Correct the estimate by one and saturate
  assign rem = x2 - qfs2;

  always_comb begin
    if (qbig2) begin
      push_height = BAR_MAX;
    end else if (rem >= X_W'(FULL_SCALE)) begin
      push_height = qe2 + HEIGHT_W'(1);
    end else begin
      push_height = qe2;
    end
  end

  assign push     = v2 && !q_full;
  assign push_idx = idx2;
  assign push_inr = inr2;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !accept)
    else $error("item accepted during store clear");

  a_height_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> push_height <= BAR_MAX)
    else $error("bar height above full scale");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && q_full) |=> (v2 && $stable(idx2) && $stable(qe2)))
    else $error("stalled front stage changed");

endmodule

// ----- src/sbph_queue.sv -----
module sbph_queue import sbph_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/sbph_back.sv -----
module sbph_back import sbph_pkg::*; #(
  parameter int ENTRIES = 256,
  parameter int IDX_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [HOLD_W-1:0]   hold_frames,
  output logic                clear_busy,
  input  logic                q_empty,
  input  logic [IDX_W-1:0]    q_idx,
  input  logic                q_inr,
  input  logic [HEIGHT_W-1:0] q_height,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output res_t                res
);

  localparam int ENT_W = HEIGHT_W + HOLD_W;

  logic [ENT_W-1:0]    store [ENTRIES];
  logic [ENT_W-1:0]    rd;
  logic [IDX_W-1:0]    clr_cnt;

  logic                bv;
  logic [IDX_W-1:0]    b_idx;
  logic                b_inr;
  logic [HEIGHT_W-1:0] b_height;
  logic                bdone;

  logic                lw_v;
  logic [IDX_W-1:0]    lw_idx;
  logic [HEIGHT_W-1:0] lw_peak;
  logic [HOLD_W-1:0]   lw_hold;

  logic [HEIGHT_W-1:0] cur_peak;
  logic [HOLD_W-1:0]   cur_hold;
  logic [HEIGHT_W-1:0] new_peak;
  logic [HOLD_W-1:0]   new_hold;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [ENT_W-1:0]    wr_data;

  assign bdone = bv && (!out_valid || !out_stall);
  assign pop   = !q_empty && !clear_busy && (!bv || bdone);

  // Sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_cnt    <= '0;
    end else if (clear_busy) begin
      if (clr_cnt == IDX_W'(ENTRIES - 1)) begin
        clear_busy <= 1'b0;
      end
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  // Take the entry from the last write when it was read stale
  always_comb begin
    if (lw_v && lw_idx == b_idx) begin
      cur_peak = lw_peak;
      cur_hold = lw_hold;
    end else begin
      cur_peak = rd[ENT_W-1:HOLD_W];
      cur_hold = rd[HOLD_W-1:0];
    end
  end

  // Refresh, hold or decay the peak
  always_comb begin
    new_peak = cur_peak;
    new_hold = cur_hold;
    priority if (b_height >= cur_peak) begin
      new_peak = b_height;
      new_hold = hold_frames;
    end else if (cur_hold != '0) begin
      new_hold = cur_hold - HOLD_W'(1);
    end else if (cur_peak != '0) begin
      new_peak = cur_peak - HEIGHT_W'(1);
    end
  end

  // Select the store write source
  always_comb begin
    if (clear_busy) begin
      wr_en   = 1'b1;
      wr_idx  = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = bdone && b_inr;
      wr_idx  = b_idx;
      wr_data = {new_peak, new_hold};
    end
  end

  // Per-bin store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_idx] <= wr_data;
    end
    if (pop) begin
      rd <= store[q_idx];
    end
  end

  // Hold the item whose entry is being read
  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else if (pop) begin
      bv <= 1'b1;
    end else if (bdone) begin
      bv <= 1'b0;
    end
    if (pop) begin
      b_idx    <= q_idx;
      b_inr    <= q_inr;
      b_height <= q_height;
    end
  end

  // Remember the last item write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_v <= 1'b0;
    end else if (bdone && b_inr) begin
      lw_v <= 1'b1;
    end
    if (bdone && b_inr) begin
      lw_idx  <= b_idx;
      lw_peak <= new_peak;
      lw_hold <= new_hold;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bdone) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (bdone) begin
      res.bar_height  <= b_height;
      res.peak_height <= b_inr ? new_peak : '0;
      res.peak_shown  <= b_inr && (new_peak != '0);
    end
  end

  // Checks
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !pop)
    else $error("queue popped during store clear");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    (bv && b_inr && !clear_busy) |-> new_peak <= BAR_MAX)
    else $error("stored peak above full scale");

  a_decay_step: assert property (@(posedge clk) disable iff (rst)
    (bdone && b_inr && lw_v && lw_idx == b_idx)
      |-> (HEIGHT_W + 1)'(new_peak) + 1 >= (HEIGHT_W + 1)'(lw_peak))
    else $error("peak dropped by more than one step");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    $fell(clear_busy) |-> $past(clr_cnt) == IDX_W'(ENTRIES - 1))
    else $error("store clear ended early");

endmodule

// ----- src/spectrum_bar_peak_hold.sv -----
// Path: front stages, queue, store read register, output register.
// Throughput: one item per cycle when not stalled, set by the single read and single write per
// cycle on the per-bin peak/hold memory; same-bin items back to back are forwarded.
// Reset (rst, synchronous): clears all control state, sets hold_frames to 20,
// then sweeps every entry of the peak/hold memory to zero with in_stall
// high; configuration writes are taken during the sweep.
module spectrum_bar_peak_hold import sbph_pkg::*; #(
  parameter int BINS       = 128,
  parameter int CHANNELS   = 2,
  parameter int FULL_SCALE = 65535
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                channel,
  input  logic [6:0]          bin,
  input  logic [MAG_W-1:0]    magnitude,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HEIGHT_W-1:0] bar_height,
  output logic [HEIGHT_W-1:0] peak_height,
  output logic                peak_shown,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int ENTRIES = CHANNELS * BINS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW      = IDX_W + 1 + HEIGHT_W;

  logic [HOLD_W-1:0]   hold_frames;
  logic                clear_busy;
  logic                push;
  logic [IDX_W-1:0]    push_idx;
  logic                push_inr;
  logic [HEIGHT_W-1:0] push_height;
  logic                q_full;
  logic                q_empty;
  logic                pop;
  logic [QW-1:0]       q_data;
  res_t                res;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames <= HOLD_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_HOLD_FRAMES) begin
      hold_frames <= pwdata[HOLD_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_HOLD_FRAMES) ? 32'(hold_frames) : '0;

  sbph_front #(
    .BINS       (BINS),
    .CHANNELS   (CHANNELS),
    .FULL_SCALE (FULL_SCALE),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .clear_busy  (clear_busy),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .channel     (channel),
    .bin         (bin),
    .magnitude   (magnitude),
    .push        (push),
    .push_idx    (push_idx),
    .push_inr    (push_inr),
    .push_height (push_height),
    .q_full      (q_full)
  );

  sbph_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_idx, push_inr, push_height}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  sbph_back #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .hold_frames (hold_frames),
    .clear_busy  (clear_busy),
    .q_empty     (q_empty),
    .q_idx       (q_data[QW-1:HEIGHT_W+1]),
    .q_inr       (q_data[HEIGHT_W]),
    .q_height    (q_data[HEIGHT_W-1:0]),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign bar_height  = res.bar_height;
  assign peak_height = res.peak_height;
  assign peak_shown  = res.peak_shown;

endmodule
